[hdl/point_in_triangle_classifier_core_macros.svh]
// Assertion macros for the point-in-triangle classifier core.
// Used by point_in_triangle_classifier_core.sv; no other dependencies.
`ifndef POINT_IN_TRIANGLE_CLASSIFIER_CORE_MACROS_SVH
`define POINT_IN_TRIANGLE_CLASSIFIER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PITC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("point_in_triangle_classifier_core: assertion failed");
// next-cycle implication, disabled during reset
`define PITC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("point_in_triangle_classifier_core: assertion failed");
`else
`define PITC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PITC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/pitc_pkg.sv]
// Types and constants of the point-in-triangle classifier core.
// No dependencies; used by point_in_triangle_classifier_core.sv.
package pitc_pkg;

	// configuration register index
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_Y = 3'd5;

	// position codes
	localparam int unsigned POS_W = 3;
	localparam logic [POS_W-1:0] POS_VERTEX_A = 3'd0;
	localparam logic [POS_W-1:0] POS_VERTEX_B = 3'd1;
	localparam logic [POS_W-1:0] POS_VERTEX_C = 3'd2;
	localparam logic [POS_W-1:0] POS_EDGE_AB  = 3'd3;
	localparam logic [POS_W-1:0] POS_EDGE_BC  = 3'd4;
	localparam logic [POS_W-1:0] POS_EDGE_CA  = 3'd5;
	localparam logic [POS_W-1:0] POS_INSIDE   = 3'd6;
	localparam logic [POS_W-1:0] POS_OUTSIDE  = 3'd7;

	// vertex hits and edge bounding-box hits of one point
	typedef struct packed {
		logic at_a;
		logic at_b;
		logic at_c;
		logic box_ab;
		logic box_bc;
		logic box_ca;
	} geo_flags_t;

	// sign and zero status of the edge cross products ab, bc and ca, and the degenerate-area flag
	typedef struct packed {
		logic zero_ab;
		logic zero_bc;
		logic zero_ca;
		logic any_neg;
		logic any_pos;
		logic degen;
	} cross_flags_t;

endpackage

[hdl/point_in_triangle_classifier_core.sv]
// Point-in-triangle classifier core; depends on pitc_pkg and the macros header.
// A point taken with start passes the registers v_s1, v_s2, v_s3 and done_q before
// its result strobe (done) rises; one point per cycle, busy is always low.
// Four register stages: differences, products, cross-product signs, classification.
// Reset (arst_n low, asynchronous) clears vertices to 0 and all valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "point_in_triangle_classifier_core_macros.svh"

module point_in_triangle_classifier_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pitc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]           cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	output logic                            done,
	output logic [pitc_pkg::POS_W-1:0]      position,
	output logic                            contained,
	output logic                            degenerate
);

	localparam int DW = COORD_BITS + 1;  // difference width
	localparam int PW = 2 * DW;          // product width
	localparam int CW = PW + 1;          // cross product width

	// configured vertices
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	// take configuration writes; ignore unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pitc_pkg::REG_VERTEX_A_X: ax_q <= cfg_data;
				pitc_pkg::REG_VERTEX_A_Y: ay_q <= cfg_data;
				pitc_pkg::REG_VERTEX_B_X: bx_q <= cfg_data;
				pitc_pkg::REG_VERTEX_B_Y: by_q <= cfg_data;
				pitc_pkg::REG_VERTEX_C_X: cx_q <= cfg_data;
				pitc_pkg::REG_VERTEX_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipeline never stalls
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1: differences and compares ----------------
	logic signed [DW-1:0] pa_x, pa_y, pb_x, pb_y, pc_x, pc_y;
	logic signed [DW-1:0] eab_x, eab_y, ebc_x, ebc_y, eca_x, eca_y;
	logic                 ge_ax, ge_ay, ge_bx, ge_by, ge_cx, ge_cy;
	logic                 le_ax, le_ay, le_bx, le_by, le_cx, le_cy;
	pitc_pkg::geo_flags_t geo;

	// sign-extend and subtract
	always_comb begin
		pa_x  = {point_x[COORD_BITS-1], point_x} - {ax_q[COORD_BITS-1], ax_q};
		pa_y  = {point_y[COORD_BITS-1], point_y} - {ay_q[COORD_BITS-1], ay_q};
		pb_x  = {point_x[COORD_BITS-1], point_x} - {bx_q[COORD_BITS-1], bx_q};
		pb_y  = {point_y[COORD_BITS-1], point_y} - {by_q[COORD_BITS-1], by_q};
		pc_x  = {point_x[COORD_BITS-1], point_x} - {cx_q[COORD_BITS-1], cx_q};
		pc_y  = {point_y[COORD_BITS-1], point_y} - {cy_q[COORD_BITS-1], cy_q};
		eab_x = {bx_q[COORD_BITS-1], bx_q} - {ax_q[COORD_BITS-1], ax_q};
		eab_y = {by_q[COORD_BITS-1], by_q} - {ay_q[COORD_BITS-1], ay_q};
		ebc_x = {cx_q[COORD_BITS-1], cx_q} - {bx_q[COORD_BITS-1], bx_q};
		ebc_y = {cy_q[COORD_BITS-1], cy_q} - {by_q[COORD_BITS-1], by_q};
		eca_x = {ax_q[COORD_BITS-1], ax_q} - {cx_q[COORD_BITS-1], cx_q};
		eca_y = {ay_q[COORD_BITS-1], ay_q} - {cy_q[COORD_BITS-1], cy_q};
	end

	// compare the point against each vertex coordinate
	always_comb begin
		ge_ax = point_x >= ax_q;
		ge_ay = point_y >= ay_q;
		ge_bx = point_x >= bx_q;
		ge_by = point_y >= by_q;
		ge_cx = point_x >= cx_q;
		ge_cy = point_y >= cy_q;
		le_ax = point_x <= ax_q;
		le_ay = point_y <= ay_q;
		le_bx = point_x <= bx_q;
		le_by = point_y <= by_q;
		le_cx = point_x <= cx_q;
		le_cy = point_y <= cy_q;
		geo.at_a   = (point_x == ax_q) && (point_y == ay_q);
		geo.at_b   = (point_x == bx_q) && (point_y == by_q);
		geo.at_c   = (point_x == cx_q) && (point_y == cy_q);
		geo.box_ab = ((ge_ax && le_bx) || (ge_bx && le_ax))
		          && ((ge_ay && le_by) || (ge_by && le_ay));
		geo.box_bc = ((ge_bx && le_cx) || (ge_cx && le_bx))
		          && ((ge_by && le_cy) || (ge_cy && le_by));
		geo.box_ca = ((ge_cx && le_ax) || (ge_ax && le_cx))
		          && ((ge_cy && le_ay) || (ge_ay && le_cy));
	end

	logic                 v_s1;
	logic signed [DW-1:0] pa_x_s1, pa_y_s1, pb_x_s1, pb_y_s1, pc_x_s1, pc_y_s1;
	logic signed [DW-1:0] eab_x_s1, eab_y_s1, ebc_x_s1, ebc_y_s1, eca_x_s1, eca_y_s1;
	pitc_pkg::geo_flags_t geo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pa_x_s1  <= pa_x;
		pa_y_s1  <= pa_y;
		pb_x_s1  <= pb_x;
		pb_y_s1  <= pb_y;
		pc_x_s1  <= pc_x;
		pc_y_s1  <= pc_y;
		eab_x_s1 <= eab_x;
		eab_y_s1 <= eab_y;
		ebc_x_s1 <= ebc_x;
		ebc_y_s1 <= ebc_y;
		eca_x_s1 <= eca_x;
		eca_y_s1 <= eca_y;
		geo_s1   <= geo;
	end

	// ---------------- stage 2: products ----------------
	logic                 v_s2;
	logic signed [PW-1:0] m1a_s2, m1b_s2, m2a_s2, m2b_s2, m3a_s2, m3b_s2;
	logic signed [PW-1:0] mda_s2, mdb_s2;
	pitc_pkg::geo_flags_t geo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	// multiply edge vectors by point offsets, and edge AB by edge CA for the area test
	always_ff @(posedge clk) begin
		m1a_s2 <= eab_x_s1 * pa_y_s1;
		m1b_s2 <= eab_y_s1 * pa_x_s1;
		m2a_s2 <= ebc_x_s1 * pb_y_s1;
		m2b_s2 <= ebc_y_s1 * pb_x_s1;
		m3a_s2 <= eca_x_s1 * pc_y_s1;
		m3b_s2 <= eca_y_s1 * pc_x_s1;
		mda_s2 <= eab_x_s1 * eca_y_s1;
		mdb_s2 <= eab_y_s1 * eca_x_s1;
		geo_s2 <= geo_s1;
	end

	// ---------------- stage 3: cross products and signs ----------------
	logic signed [CW-1:0]   c1, c2, c3, cd;
	pitc_pkg::cross_flags_t xf;

	always_comb begin
		c1 = {m1a_s2[PW-1], m1a_s2} - {m1b_s2[PW-1], m1b_s2};
		c2 = {m2a_s2[PW-1], m2a_s2} - {m2b_s2[PW-1], m2b_s2};
		c3 = {m3a_s2[PW-1], m3a_s2} - {m3b_s2[PW-1], m3b_s2};
		// area test uses (b - a) x (a - c), zero exactly when the area is zero
		cd = {mda_s2[PW-1], mda_s2} - {mdb_s2[PW-1], mdb_s2};
		xf.zero_ab = (c1 == '0);
		xf.zero_bc = (c2 == '0);
		xf.zero_ca = (c3 == '0);
		xf.any_neg = c1[CW-1] || c2[CW-1] || c3[CW-1];
		xf.any_pos = (!c1[CW-1] && !xf.zero_ab) || (!c2[CW-1] && !xf.zero_bc)
		          || (!c3[CW-1] && !xf.zero_ca);
		xf.degen   = (cd == '0);
	end

	logic                   v_s3;
	pitc_pkg::geo_flags_t   geo_s3;
	pitc_pkg::cross_flags_t xf_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		geo_s3 <= geo_s2;
		xf_s3  <= xf;
	end

	// ---------------- stage 4: classify and drive result ----------------
	logic [pitc_pkg::POS_W-1:0] pos_d;

	// first match in order: vertices, edges, then inside or outside
	always_comb begin
		priority if (geo_s3.at_a) begin
			pos_d = pitc_pkg::POS_VERTEX_A;
		end else if (geo_s3.at_b) begin
			pos_d = pitc_pkg::POS_VERTEX_B;
		end else if (geo_s3.at_c) begin
			pos_d = pitc_pkg::POS_VERTEX_C;
		end else if (xf_s3.zero_ab && geo_s3.box_ab) begin
			pos_d = pitc_pkg::POS_EDGE_AB;
		end else if (xf_s3.zero_bc && geo_s3.box_bc) begin
			pos_d = pitc_pkg::POS_EDGE_BC;
		end else if (xf_s3.zero_ca && geo_s3.box_ca) begin
			pos_d = pitc_pkg::POS_EDGE_CA;
		end else if (xf_s3.degen || (xf_s3.any_neg && xf_s3.any_pos)) begin
			pos_d = pitc_pkg::POS_OUTSIDE;
		end else begin
			pos_d = pitc_pkg::POS_INSIDE;
		end
	end

	logic                       done_q;
	logic [pitc_pkg::POS_W-1:0] position_q;
	logic                       contained_q;
	logic                       degenerate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		position_q   <= pos_d;
		contained_q  <= (pos_d != pitc_pkg::POS_OUTSIDE);
		degenerate_q <= xf_s3.degen;
	end

	assign done       = done_q;
	assign position   = position_q;
	assign contained  = contained_q;
	assign degenerate = degenerate_q;

	// ---------------- assertions ----------------
	`PITC_ASSERT_NXT(a_accept_enters, clk, arst_n, accept, v_s1)
	`PITC_ASSERT_NXT(a_s3_to_done, clk, arst_n, v_s3, done)
	`PITC_ASSERT_IMP(a_contained_match, clk, arst_n, done, contained == (position != pitc_pkg::POS_OUTSIDE))
	`PITC_ASSERT_IMP(a_degen_not_inside, clk, arst_n, done && degenerate, position != pitc_pkg::POS_INSIDE)

endmodule
